### design/smf_pkg.sv
// Shared types for the sliding-window median filter.
// No dependencies; imported by smf_cell, smf_select and the top level.
package smf_pkg;

  // Per-cycle controls from the top level to the window cells and the output stage.
  typedef struct packed {
    logic shift;    // a new word enters the window, every cell takes its neighbor's sample
    logic capture;  // the output register takes the median of the current window
  } smf_ctl_t;

endpackage

### design/smf_cell.sv
// One window cell: holds one sample, shifts it on, and ranks it against the window.
// Depends on smf_pkg.
module smf_cell import smf_pkg::*; #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 24,
  parameter int IDX         = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  smf_ctl_t                             ctl_i,
  input  logic            [SAMPLE_BITS-1:0]    shift_i,
  input  logic [WINDOW-1:0][SAMPLE_BITS-1:0]   win_i,
  output logic            [SAMPLE_BITS-1:0]    sample_o,
  output logic                                 hit_o
);

  localparam int RankBits = $clog2(WINDOW);
  localparam logic [RankBits-1:0] MidRank = RankBits'(WINDOW / 2);

  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [RankBits-1:0]    rank;

  assign sample_d = ctl_i.shift ? shift_i : sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  // Rank = number of entries sorted ahead of this one; equal values are ordered
  // by cell index so every cell gets a distinct rank.
  always_comb begin
    logic ahead;
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      ahead = 1'b0;
      if (j != IDX) begin
        ahead = ($signed(win_i[j]) < $signed(sample_q)) ||
                ((win_i[j] == sample_q) && (j < IDX));
      end
      rank = rank + RankBits'(ahead);
    end
  end

  assign hit_o    = (rank == MidRank);
  assign sample_o = sample_q;

endmodule

### design/smf_select.sv
// Output stage: picks the cell whose rank is the middle one and registers it.
// Depends on smf_pkg.
module smf_select import smf_pkg::*; #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  smf_ctl_t                             ctl_i,
  input  logic [WINDOW-1:0][SAMPLE_BITS-1:0]   win_i,
  input  logic [WINDOW-1:0]                    hit_i,
  output logic            [SAMPLE_BITS-1:0]    median_o
);

  logic [SAMPLE_BITS-1:0] median_q, median_d, pick;

  // hit_i is one-hot, so an AND-OR mux is enough
  always_comb begin
    pick = '0;
    for (int i = 0; i < WINDOW; i++) begin
      pick = pick | (win_i[i] & {SAMPLE_BITS{hit_i[i]}});
    end
  end

  assign median_d = ctl_i.capture ? pick : median_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      median_q <= '0;
    end else begin
      median_q <= median_d;
    end
  end

  assign median_o = median_q;

endmodule

### design/sliding_median_filter_unit.sv
// Sliding-window median filter: a row of WINDOW shift cells, each ranking its sample.
// An accepted word enters cell 0; its median is registered once the output is free.
// Throughput: one word per cycle; the rank compares of every cell run in parallel,
// and only a held output while a median waits to move stalls the input.
// Reset (rst_ni low, asynchronous) zeroes all window cells and drops both valids.
// Depends on smf_pkg, smf_cell and smf_select.
module sliding_median_filter_unit import smf_pkg::*; #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          sample_valid_i,
  output logic                          sample_stall_o,
  output logic signed [SAMPLE_BITS-1:0] median_o,
  output logic                          median_valid_o,
  input  logic                          median_stall_i
);

  smf_ctl_t                           ctl;
  logic [WINDOW-1:0][SAMPLE_BITS-1:0] win;
  logic [WINDOW-1:0]                  hit;
  logic [SAMPLE_BITS-1:0]             median;
  logic                               pend_q, pend_d;
  logic                               out_vld_q, out_vld_d;
  logic                               out_free, in_acc;

  // pend_q: window changed, its median not yet in the output register
  assign out_free       = !out_vld_q || !median_stall_i;
  assign ctl.capture    = pend_q && out_free;
  assign sample_stall_o = pend_q && !out_free;
  assign in_acc         = sample_valid_i && !sample_stall_o;
  assign ctl.shift      = in_acc;

  assign pend_d    = in_acc || (pend_q && !ctl.capture);
  assign out_vld_d = ctl.capture || (out_vld_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Cell 0 holds the newest sample; the oldest falls off the far end.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] shift_in;
    if (i == 0) begin : g_head
      assign shift_in = sample_i;
    end else begin : g_body
      assign shift_in = win[i-1];
    end
    smf_cell #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX         (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .shift_i  (shift_in),
      .win_i    (win),
      .sample_o (win[i]),
      .hit_o    (hit[i])
    );
  end

  smf_select #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .win_i    (win),
    .hit_i    (hit),
    .median_o (median)
  );

  assign median_o       = $signed(median);
  assign median_valid_o = out_vld_q;

  a_rank_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(hit))
    else $error("window ranks do not select exactly one cell");

  a_accept_pends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pend_q)
    else $error("accepted word left no pending median");

  a_held_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && median_stall_i) |=> (out_vld_q && $stable(median)))
    else $error("stalled median lost or changed");

  a_no_idle_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> !sample_stall_o)
    else $error("input stalled with no pending median");

  a_capture_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.capture && !in_acc) |=> !pend_q)
    else $error("pending flag kept after capture");

endmodule

### dv/tb_sliding_median_filter_unit.sv
// Self-checking testbench for sliding_median_filter_unit: directed table, then random words.
// A predictor keeps its own window and slot and checks every median; valid/stall on both sides.
// Depends only on the RTL of the filter (top level and what it pulls in).
`timescale 1ns / 100ps

module tb_sliding_median_filter_unit;

  localparam int WIN         = 5;
  localparam int BITS        = 24;
  localparam int NPROBE      = 22;
  localparam int RAND_WORDS  = 1600;
  localparam int QUIET_WORDS = 200;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [BITS-1:0] ALT_MAX  = 24'sh7FFFFF;
  localparam logic signed [BITS-1:0] ALT_MIN  = 24'sh800000;
  localparam logic signed [BITS-1:0] ALT_ZERO = 24'sh000000;
  localparam logic signed [BITS-1:0] ALT_NEG1 = 24'shFFFFFF;

  typedef enum int {
    WORD_FULL, WORD_NEAR_ZERO, WORD_EXTREME, WORD_TIE, WORD_CLUSTER
  } word_kind_e;

  typedef struct packed {
    logic signed [BITS-1:0] word;
    logic                   typed;   // median below is known by inspection
    logic signed [BITS-1:0] median;
  } probe_row_t;

  // Starts from the all-zero window; the -1 run fills every slot with equal words.
  probe_row_t probe_rows [NPROBE] = '{
    '{ALT_ZERO, 1'b1, ALT_ZERO},
    '{ALT_MAX,  1'b1, ALT_ZERO},
    '{ALT_MIN,  1'b1, ALT_ZERO},
    '{ALT_MAX,  1'b1, ALT_ZERO},
    '{ALT_MAX,  1'b1, ALT_MAX},
    '{ALT_MIN,  1'b1, ALT_MAX},   // slot wrapped back to the first entry
    '{ALT_MIN,  1'b1, ALT_MIN},
    '{ALT_NEG1, 1'b0, ALT_ZERO},
    '{ALT_NEG1, 1'b0, ALT_ZERO},
    '{ALT_NEG1, 1'b0, ALT_ZERO},
    '{ALT_NEG1, 1'b0, ALT_ZERO},
    '{ALT_NEG1, 1'b1, ALT_NEG1},
    '{24'sh555555, 1'b0, ALT_ZERO},
    '{24'shAAAAAA, 1'b0, ALT_ZERO},
    '{24'sh000001, 1'b0, ALT_ZERO},
    '{24'shFFFFFE, 1'b0, ALT_ZERO},
    '{24'sh400000, 1'b0, ALT_ZERO},
    '{24'shC00000, 1'b0, ALT_ZERO},
    '{24'sh000100, 1'b0, ALT_ZERO},
    '{24'sh0186A0, 1'b0, ALT_ZERO},
    '{24'sh123456, 1'b0, ALT_ZERO},
    '{24'shFEDCBA, 1'b0, ALT_ZERO}
  };

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic signed [BITS-1:0] sample_i       = '0;
  logic                   sample_valid_i = 1'b0;
  logic                   median_stall_i = 1'b0;
  logic                   sample_stall_o;
  logic signed [BITS-1:0] median_o;
  logic                   median_valid_o;

  sliding_median_filter_unit #(
    .WINDOW      (WIN),
    .SAMPLE_BITS (BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .median_o       (median_o),
    .median_valid_o (median_valid_o),
    .median_stall_i (median_stall_i)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic signed [BITS-1:0] alt_window [WIN];
  int unsigned            next_slot;

  logic signed [BITS-1:0] median_due_q [$];
  logic signed [BITS-1:0] median_due;
  int unsigned            errors;
  int unsigned            words_sent;
  int unsigned            medians_seen;
  int unsigned            input_held_cycles;
  int unsigned            holds_done;
  int unsigned            cycle_count;
  bit                     hold_request;
  bit                     drain_mode;

  function automatic logic signed [BITS-1:0] window_median(
    input logic signed [BITS-1:0] w [WIN]
  );
    logic signed [BITS-1:0] s [WIN];
    logic signed [BITS-1:0] key;
    int                     j;
    s = w;
    for (int i = 1; i < WIN; i++) begin
      key = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > key) begin
        s[j+1] = s[j];
        j--;
      end
      s[j+1] = key;
    end
    return s[WIN/2];
  endfunction

  function automatic logic signed [BITS-1:0] filter_accept(input logic signed [BITS-1:0] word);
    alt_window[next_slot] = word;
    next_slot = (next_slot + 1) % WIN;
    return window_median(alt_window);
  endfunction

  // Offer one word, hold it until taken, then maybe leave a gap.
  task automatic send_word(
    input logic signed [BITS-1:0] word,
    input logic                   typed,
    input logic signed [BITS-1:0] typed_median
  );
    logic signed [BITS-1:0] m;
    int                     gap;
    sample_i       <= word;
    sample_valid_i <= 1'b1;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
    m = filter_accept(word);
    median_due_q.push_back(typed ? typed_median : m);
    words_sent++;
    if (!drain_mode && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      sample_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Output side: check each taken word, count cycles, watch the limit.
  always @(posedge clk_i) begin
    if (rst_ni && median_valid_o && !median_stall_i) begin
      if (median_due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected median word: expected none, actual %0d", $time, median_o);
      end else begin
        median_due = median_due_q.pop_front();
        medians_seen++;
        if (median_o !== median_due) begin
          errors++;
          $display("%0t: median mismatch: expected %0d, actual %0d",
                   $time, median_due, median_o);
        end
      end
    end
    if (sample_valid_i && sample_stall_o) input_held_cycles++;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tb_sliding_median_filter_unit: done, errors");
      $finish;
    end
  end

  // Receiver stall: random runs of stall and go, plus long holds on request.
  initial begin
    int   run_left;
    logic level;
    run_left = 0;
    level    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        level        = 1'b1;
        run_left     = HOLD_CYCLES;
        holds_done++;
      end else if (drain_mode) begin
        level    = 1'b0;
        run_left = 0;
      end else if (run_left == 0) begin
        level    = ($urandom_range(0, 2) == 0);
        run_left = level ? $urandom_range(1, 19) : $urandom_range(1, 40);
      end
      median_stall_i <= level;
      if (run_left > 0) run_left--;
    end
  end

  initial begin
    logic signed [BITS-1:0] word;
    logic signed [BITS-1:0] last_word;
    word_kind_e             kind;
    int unsigned            pick;
    foreach (alt_window[k]) alt_window[k] = '0;
    next_slot = 0;
    last_word = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NPROBE; r++) begin
      send_word(probe_rows[r].word, probe_rows[r].typed, probe_rows[r].median);
    end

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == 600 || n == 1100) hold_request = 1'b1;
      if (n == RAND_WORDS - QUIET_WORDS) drain_mode = 1'b1;
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? WORD_FULL :
             (pick < 6) ? WORD_NEAR_ZERO :
             (pick < 7) ? WORD_EXTREME :
             (pick < 9) ? WORD_TIE : WORD_CLUSTER;
      case (kind)
        WORD_FULL:      word = BITS'($urandom);
        WORD_NEAR_ZERO: word = BITS'(int'($urandom_range(0, 512)) - 256);
        WORD_EXTREME: begin
          case ($urandom_range(0, 3))
            0:       word = ALT_MAX;
            1:       word = ALT_MIN;
            2:       word = ALT_ZERO;
            default: word = ALT_NEG1;
          endcase
        end
        WORD_TIE:       word = last_word;
        default:        word = last_word + BITS'(int'($urandom_range(0, 64)) - 32);
      endcase
      send_word(word, 1'b0, '0);
      last_word = word;
    end
    sample_valid_i <= 1'b0;

    while (median_due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words (%0d directed), checked %0d medians, %0d long output holds.",
             words_sent, NPROBE, medians_seen, holds_done);
    $display("Input was held off for %0d cycles; %0d mismatches.", input_held_cycles, errors);
    if (errors == 0) begin
      $display("tb_sliding_median_filter_unit: done, clean");
    end else begin
      $display("tb_sliding_median_filter_unit: done, errors");
    end
    $finish;
  end

endmodule
